@@ sv/v3a_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_pkg
// Opcode type shared by the 3D vector ALU.
// ----------------------------------------------------------------------------
package v3a_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_CROSS = 3'd2,
    OP_DOT   = 3'd3,
    OP_SCALE = 3'd4,
    OP_LEN   = 3'd5,
    OP_NORM  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

endpackage
`default_nettype wire

@@ sv/v3a_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_if
// Valid/ready channel carrying a payload of parametric width.
// ----------------------------------------------------------------------------
interface v3a_if #(
  parameter int unsigned PayloadWidth = 8
) ();
  logic                    valid;
  logic                    ready;
  logic [PayloadWidth-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/vector3_alu_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_alu_core
// 3D vector ALU in signed fixed point, three parallel component lanes.
// ----------------------------------------------------------------------------
// Usage: req_i carries {req_type, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor}
// (req_type in the top bits), rsp_o carries {r_x, r_y, r_z, r_scalar,
// saturated}. Both are valid/ready; an item moves when valid and ready are
// high at a clock edge.
// Throughput: one item per cycle while the output stage is not stalled. Every
// item goes through one fixed-length pipeline: a multiply stage in each lane,
// a sum stage, a square-root pipeline of DATA_WIDTH+1 stages and a divider of
// DATA_WIDTH+FRAC_BITS stages, then the merge/saturate stage.
// Stalls: the whole pipeline holds while the output stage is full and not
// taken; req_i ready follows the output stage, so no item is dropped.
// Reset: clears all valid bits; the data path carries no reset.
// ----------------------------------------------------------------------------
module vector3_alu_core #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  v3a_if.sink    req_i,
  v3a_if.source  rsp_o
);
  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned SW  = 2*W + 2;
  localparam int unsigned NW  = W + FRAC_BITS;
  localparam int unsigned LAT = 2 + (SW/2) + NW;

  typedef logic signed [W-1:0] dat_t;
  typedef struct packed {
    v3a_pkg::op_e op;
    dat_t ax, ay, az, bx, by, bz, sf;
  } req_t;
  typedef struct packed {
    dat_t rx, ry, rz, rs;
    logic sat;
  } rsp_t;

  req_t req;
  assign req = req_t'(req_i.payload);

  logic en;
  logic [LAT-1:0] vld_q;
  logic out_vld_q;
  rsp_t out_q;
  assign en = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.payload = out_q;

  // lane operand selection
  dat_t l0a [3], l0b [3], l1a [3], l1b [3];
  logic lsub [3];
  dat_t av [3], bv [3];
  assign av[0] = req.ax; assign av[1] = req.ay; assign av[2] = req.az;
  assign bv[0] = req.bx; assign bv[1] = req.by; assign bv[2] = req.bz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l0a[i] = av[(i+1)%3]; l0b[i] = bv[(i+2)%3];
      l1a[i] = av[(i+2)%3]; l1b[i] = bv[(i+1)%3];
      lsub[i] = 1'b1;
      unique case (req.op)
        v3a_pkg::OP_DOT: begin
          l0a[i] = av[i]; l0b[i] = bv[i]; l1a[i] = '0; l1b[i] = '0; lsub[i] = 1'b0;
        end
        v3a_pkg::OP_SCALE: begin
          l0a[i] = av[i]; l0b[i] = req.sf; l1a[i] = '0; l1b[i] = '0; lsub[i] = 1'b0;
        end
        v3a_pkg::OP_LEN, v3a_pkg::OP_NORM: begin
          l0a[i] = av[i]; l0b[i] = av[i]; l1a[i] = '0; l1b[i] = '0; lsub[i] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  logic signed [SW-1:0] lsum [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane #(.DataWidth(W)) u_lane (
      .clk_i(clk_i), .en_i(en),
      .p0a_i(l0a[i]), .p0b_i(l0b[i]), .p1a_i(l1a[i]), .p1b_i(l1b[i]),
      .sub_i(lsub[i]), .sum_o(lsum[i])
    );
  end

  // stage 1 registers: request bits that travel with the lanes
  req_t r1_q;
  always_ff @(posedge clk_i) if (en) r1_q <= req;

  // stage 2: lane results and merged sum
  logic signed [SW-1:0] s2_lane_q [3];
  logic signed [SW-1:0] s2_sum_q;
  req_t r2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s2_lane_q[i] <= lsum[i];
      s2_sum_q <= lsum[0] + lsum[1] + lsum[2];
      r2_q     <= r1_q;
    end
  end

  // square root over the sum of squares (non-negative for length ops)
  localparam int unsigned RW = SW / 2;
  logic [RW-1:0] root;
  v3a_sqrt #(.InWidth(SW)) u_sqrt (
    .clk_i(clk_i), .en_i(en), .rad_i(s2_sum_q), .root_o(root)
  );

  // delay line to align with the square root
  logic signed [SW-1:0] d3_lane_q [RW+1][3];
  logic signed [SW-1:0] d3_sum_q  [RW+1];
  req_t d3_req_q [RW+1];
  always_comb begin
    d3_lane_q[0] = s2_lane_q;
    d3_sum_q[0]  = s2_sum_q;
    d3_req_q[0]  = r2_q;
  end
  for (genvar s = 0; s < RW; s++) begin : g_d3
    always_ff @(posedge clk_i) begin
      if (en) begin
        d3_lane_q[s+1] <= d3_lane_q[s];
        d3_sum_q[s+1]  <= d3_sum_q[s];
        d3_req_q[s+1]  <= d3_req_q[s];
      end
    end
  end

  // divider lanes: |a_i| << FRAC_BITS / len
  logic [NW-1:0] quo [3];
  dat_t aa [3];
  logic [NW-1:0] num [3];
  assign aa[0] = d3_req_q[RW].ax;
  assign aa[1] = d3_req_q[RW].ay;
  assign aa[2] = d3_req_q[RW].az;
  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [W-1:0] mag;
    assign mag    = aa[i][W-1] ? W'(-aa[i]) : W'(aa[i]);
    assign num[i] = {mag, FRAC_BITS'(0)};
    v3a_div #(.NumWidth(NW), .DenWidth(RW)) u_div (
      .clk_i(clk_i), .en_i(en), .num_i(num[i]),
      .den_i((root == '0) ? RW'(1) : root), .quo_o(quo[i])
    );
  end

  logic signed [SW-1:0] d4_lane_q [NW+1][3];
  logic signed [SW-1:0] d4_sum_q  [NW+1];
  logic [RW-1:0]        d4_root_q [NW+1];
  req_t d4_req_q [NW+1];
  always_comb begin
    d4_lane_q[0] = d3_lane_q[RW];
    d4_sum_q[0]  = d3_sum_q[RW];
    d4_root_q[0] = root;
    d4_req_q[0]  = d3_req_q[RW];
  end
  for (genvar s = 0; s < NW; s++) begin : g_d4
    always_ff @(posedge clk_i) begin
      if (en) begin
        d4_lane_q[s+1] <= d4_lane_q[s];
        d4_sum_q[s+1]  <= d4_sum_q[s];
        d4_root_q[s+1] <= d4_root_q[s];
        d4_req_q[s+1]  <= d4_req_q[s];
      end
    end
  end

  // merge and saturate
  localparam int unsigned XW = SW + 1;
  function automatic dat_t clampf(input logic signed [XW-1:0] v, output logic f);
    logic signed [XW-1:0] mx, mn;
    mx = XW'({1'b0, {(W-1){1'b1}}});
    mn = -mx - XW'(1);
    f = 1'b0;
    if (v > mx) begin
      f = 1'b1; return dat_t'(mx[W-1:0]);
    end else if (v < mn) begin
      f = 1'b1; return dat_t'(mn[W-1:0]);
    end
    return dat_t'(v[W-1:0]);
  endfunction

  req_t rf;
  dat_t fa [3];
  rsp_t res;
  always_comb begin
    logic f0, f1, f2, f3;
    logic signed [XW-1:0] t;
    rf  = d4_req_q[NW];
    fa[0] = rf.ax; fa[1] = rf.ay; fa[2] = rf.az;
    res = '0;
    f0 = 1'b0; f1 = 1'b0; f2 = 1'b0; f3 = 1'b0;
    t = '0;
    unique case (rf.op)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
        t = (rf.op == v3a_pkg::OP_ADD) ? XW'(rf.ax) + XW'(rf.bx) : XW'(rf.ax) - XW'(rf.bx);
        res.rx = clampf(t, f0);
        t = (rf.op == v3a_pkg::OP_ADD) ? XW'(rf.ay) + XW'(rf.by) : XW'(rf.ay) - XW'(rf.by);
        res.ry = clampf(t, f1);
        t = (rf.op == v3a_pkg::OP_ADD) ? XW'(rf.az) + XW'(rf.bz) : XW'(rf.az) - XW'(rf.bz);
        res.rz = clampf(t, f2);
      end
      v3a_pkg::OP_CROSS, v3a_pkg::OP_SCALE: begin
        res.rx = clampf(XW'(d4_lane_q[NW][0] >>> FRAC_BITS), f0);
        res.ry = clampf(XW'(d4_lane_q[NW][1] >>> FRAC_BITS), f1);
        res.rz = clampf(XW'(d4_lane_q[NW][2] >>> FRAC_BITS), f2);
      end
      v3a_pkg::OP_DOT: begin
        res.rs = clampf(XW'(d4_sum_q[NW] >>> FRAC_BITS), f3);
      end
      v3a_pkg::OP_LEN: begin
        res.rs = clampf(XW'({1'b0, d4_root_q[NW]}), f3);
      end
      v3a_pkg::OP_NORM: begin
        if (d4_root_q[NW] == '0) begin
          res.rx = fa[0]; res.ry = fa[1]; res.rz = fa[2];
        end else begin
          t = fa[0][W-1] ? -XW'(quo[0]) : XW'(quo[0]);
          res.rx = clampf(t, f0);
          t = fa[1][W-1] ? -XW'(quo[1]) : XW'(quo[1]);
          res.ry = clampf(t, f1);
          t = fa[2][W-1] ? -XW'(quo[2]) : XW'(quo[2]);
          res.rz = clampf(t, f2);
        end
      end
      default: ;
    endcase
    res.sat = f0 | f1 | f2 | f3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LAT-2:0], req_i.valid};
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) if (en) out_q <= res;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.payload))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> req_i.ready)
    else $error("not ready with empty output stage");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline advanced during stall");
endmodule
`default_nettype wire

@@ sv/v3a_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_lane
// One component lane: registered signed product pair, then their combinational sum or difference.
// ----------------------------------------------------------------------------
module v3a_lane #(
  parameter int unsigned DataWidth = 32
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire signed [DataWidth-1:0]   p0a_i,
  input  wire signed [DataWidth-1:0]   p0b_i,
  input  wire signed [DataWidth-1:0]   p1a_i,
  input  wire signed [DataWidth-1:0]   p1b_i,
  input  wire                          sub_i,
  output logic signed [2*DataWidth+1:0] sum_o
);
  logic signed [2*DataWidth-1:0] m0_q, m1_q;
  logic sub_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q  <= p0a_i * p0b_i;
      m1_q  <= p1a_i * p1b_i;
      sub_q <= sub_i;
    end
  end

  always_comb begin
    if (sub_q) begin
      sum_o = {{2{m0_q[2*DataWidth-1]}}, m0_q} - {{2{m1_q[2*DataWidth-1]}}, m1_q};
    end else begin
      sum_o = {{2{m0_q[2*DataWidth-1]}}, m0_q} + {{2{m1_q[2*DataWidth-1]}}, m1_q};
    end
  end
endmodule
`default_nettype wire

@@ sv/v3a_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v3a_sqrt #(
  parameter int unsigned InWidth = 66
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire  [InWidth-1:0]       rad_i,
  output logic [InWidth/2-1:0]     root_o
);
  localparam int unsigned RW = InWidth / 2;

  logic [InWidth-1:0] rad_q  [RW+1];
  logic [RW-1:0]      root_q [RW+1];
  logic [InWidth+1:0] rem_q  [RW+1];

  always_comb begin
    rad_q[0]  = rad_i;
    root_q[0] = '0;
    rem_q[0]  = '0;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [InWidth+1:0] rem_sh, trial;
    logic [InWidth-1:0] rad_sh;
    assign rem_sh = {rem_q[s][InWidth-1:0], rad_q[s][InWidth-1 -: 2]};
    assign rad_sh = {rad_q[s][InWidth-3:0], 2'b00};
    assign trial  = (InWidth+2)'({root_q[s], 2'b01});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1] <= rad_sh;
        if (rem_sh >= trial) begin
          rem_q[s+1]  <= rem_sh - trial;
          root_q[s+1] <= {root_q[s][RW-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= rem_sh;
          root_q[s+1] <= {root_q[s][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RW];
endmodule
`default_nettype wire

@@ sv/v3a_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter int unsigned NumWidth = 48,
  parameter int unsigned DenWidth = 33
) (
  input  wire                  clk_i,
  input  wire                  en_i,
  input  wire  [NumWidth-1:0]  num_i,
  input  wire  [DenWidth-1:0]  den_i,
  output logic [NumWidth-1:0]  quo_o
);
  logic [NumWidth-1:0] num_q [NumWidth+1];
  logic [DenWidth-1:0] den_q [NumWidth+1];
  logic [DenWidth:0]   rem_q [NumWidth+1];

  always_comb begin
    num_q[0] = num_i;
    den_q[0] = den_i;
    rem_q[0] = '0;
  end

  for (genvar s = 0; s < NumWidth; s++) begin : g_stage
    logic [DenWidth+1:0] rs;
    assign rs = {rem_q[s], num_q[s][NumWidth-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        if (rs >= {2'b00, den_q[s]}) begin
          rem_q[s+1] <= (DenWidth+1)'(rs - {2'b00, den_q[s]});
          num_q[s+1] <= {num_q[s][NumWidth-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= rs[DenWidth:0];
          num_q[s+1] <= {num_q[s][NumWidth-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = num_q[NumWidth];
endmodule
`default_nettype wire

@@ test/vector3_alu_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_alu_chk
// Watches the request and response channels of the vector ALU, computes the
// expected response of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module vector3_alu_chk (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         req_valid_i,
  input  wire         req_ready_i,
  input  wire [226:0] req_payload_i,
  input  wire         rsp_valid_i,
  input  wire         rsp_ready_i,
  input  wire [128:0] rsp_payload_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          rsp_cnt_o
);
  localparam int FRAC = 16;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic               saturated;
  } vec_rsp_t;

  vec_rsp_t expected_q[$];

  // Clamp a wide signed value to 32 bits, flagging when clamped.
  function automatic logic [31:0] clamp32(input logic signed [129:0] v, inout logic flag);
    if (v > 130'sd2147483647) begin
      flag = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -130'sd2147483648) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [129:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [129:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      sq = 130'(c) * 130'(c);
      if (sq <= s) r = c;
    end
    return r;
  endfunction

  function automatic vec_rsp_t alu_result(input logic [226:0] p);
    v3a_pkg::op_e        op;
    logic signed [31:0]  a[3];
    logic signed [31:0]  b[3];
    logic signed [31:0]  s;
    logic signed [129:0] t;
    logic [129:0]        sum;
    logic [63:0]         len;
    logic [129:0]        mag;
    logic [129:0]        q;
    logic [31:0]         v[3];
    logic [31:0]         sc;
    logic                f;
    vec_rsp_t            r;
    op = v3a_pkg::op_e'(p[226:224]);
    a[0] = p[223:192]; a[1] = p[191:160]; a[2] = p[159:128];
    b[0] = p[127:96];  b[1] = p[95:64];   b[2] = p[63:32];
    s = p[31:0];
    v[0] = '0; v[1] = '0; v[2] = '0; sc = '0; f = 1'b0;
    sum = '0;
    for (int i = 0; i < 3; i++) sum += 130'(64'($signed(a[i])) * 64'($signed(a[i])));
    case (op)
      v3a_pkg::OP_ADD: for (int i = 0; i < 3; i++)
        v[i] = clamp32(130'(signed'(a[i])) + 130'(signed'(b[i])), f);
      v3a_pkg::OP_SUB: for (int i = 0; i < 3; i++)
        v[i] = clamp32(130'(signed'(a[i])) - 130'(signed'(b[i])), f);
      v3a_pkg::OP_CROSS: for (int i = 0; i < 3; i++) begin
        t = 130'(64'(a[(i+1)%3]) * 64'(b[(i+2)%3])) - 130'(64'(a[(i+2)%3]) * 64'(b[(i+1)%3]));
        v[i] = clamp32(t >>> FRAC, f);
      end
      v3a_pkg::OP_DOT: begin
        t = '0;
        for (int i = 0; i < 3; i++) t += 130'(64'(a[i]) * 64'(b[i]));
        sc = clamp32(t >>> FRAC, f);
      end
      v3a_pkg::OP_SCALE: for (int i = 0; i < 3; i++)
        v[i] = clamp32(130'(64'(a[i]) * 64'(s)) >>> FRAC, f);
      v3a_pkg::OP_LEN: sc = clamp32(130'(root_floor(sum)), f);
      v3a_pkg::OP_NORM: begin
        len = root_floor(sum);
        if (len == 0) begin
          for (int i = 0; i < 3; i++) v[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++) begin
            mag = a[i] < 0 ? 130'(-65'(a[i])) : 130'(a[i]);
            q = (mag << FRAC) / 130'(len);
            t = a[i] < 0 ? -signed'(q) : signed'(q);
            v[i] = clamp32(t, f);
          end
        end
      end
      default: ;
    endcase
    r.r_x = v[0]; r.r_y = v[1]; r.r_z = v[2]; r.r_scalar = sc; r.saturated = f;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    rsp_cnt_o  = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i) begin
    vec_rsp_t got;
    vec_rsp_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) expected_q.push_back(alu_result(req_payload_i));
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_payload_i;
        rsp_cnt_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", 32'(got.saturated), 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (got.r_x !== want.r_x) report_mismatch("r_x", got.r_x, want.r_x);
          if (got.r_y !== want.r_y) report_mismatch("r_y", got.r_y, want.r_y);
          if (got.r_z !== want.r_z) report_mismatch("r_z", got.r_z, want.r_z);
          if (got.r_scalar !== want.r_scalar)
            report_mismatch("r_scalar", got.r_scalar, want.r_scalar);
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        end
      end
      pending_o = expected_q.size();
    end
  end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives random and corner-case vector requests into the ALU with random
// gaps and back-pressure; the checker compares every response.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_RANDOM = 1530;
  localparam int LATENCY    = 83;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   rsp_cnt;
  int   sent_cnt;
  int   idle_cycles;
  bit   stim_done;
  bit   hold_off;
  int   op_cnt[8];

  v3a_if #(.PayloadWidth(227)) req_if ();
  v3a_if #(.PayloadWidth(129)) rsp_if ();

  always #5 clk_i = ~clk_i;

  vector3_alu_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  vector3_alu_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_payload_i (req_if.payload),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_payload_i (rsp_if.payload),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .rsp_cnt_o     (rsp_cnt)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 3) return $urandom_range(20, 80);
    if ($urandom_range(0, 99) < 50) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Mix of corner values, small magnitudes and full-range words.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff);
      5: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_req(input v3a_pkg::op_e op, input logic [31:0] w[7]);
    req_if.payload <= {op, w[0], w[1], w[2], w[3], w[4], w[5], w[6]};
    req_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_cnt++;
    op_cnt[op]++;
    @(negedge clk_i);
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic run_stimulus();
    logic [31:0] w[7];
    logic [31:0] mx;
    logic [31:0] mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // directed: extremes of every field, each opcode including the unused one
    for (int o = 0; o < 8; o++) begin
      w = '{mx, mx, mx, mn, mn, mn, mx};
      send_req(v3a_pkg::op_e'(o), w);
      w = '{mn, mn, mn, mn, mn, mn, mn};
      send_req(v3a_pkg::op_e'(o), w);
    end
    w = '{0, 0, 0, 5, 6, 7, 9};
    send_req(v3a_pkg::OP_NORM, w);           // zero-length normalize
    w = '{32'h00030000, 32'h00040000, 0, 0, 0, 0, 0};
    send_req(v3a_pkg::OP_NORM, w);
    send_req(v3a_pkg::OP_LEN, w);
    w = '{32'h00010000, 0, 0, 0, 32'h00010000, 0, 32'hffff0000};
    send_req(v3a_pkg::OP_CROSS, w);
    send_req(v3a_pkg::OP_SCALE, w);
    w = '{1, 0, 0, 0, 0, 0, 0};
    send_req(v3a_pkg::OP_NORM, w);           // tiny vector
    w = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 32'hffffffff};
    send_req(v3a_pkg::OP_DOT, w);
    send_req(v3a_pkg::OP_SCALE, w);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      for (int k = 0; k < 7; k++) w[k] = rand_word();
      send_req(v3a_pkg::op_e'($urandom_range(0, 7)), w);
      send_gap();
    end
    req_if.valid <= 1'b0;
    stim_done = 1'b1;
  endtask

  // response side: random stalls plus one long hold-off to fill the pipeline
  initial begin
    int g;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      rsp_if.ready <= 1'b1;
      @(negedge clk_i);
      if ($urandom_range(0, 99) < 30) begin
        g = gap_len();
        if (g > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    sent_cnt       = 0;
    stim_done      = 1'b0;
    hold_off       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    fork
      run_stimulus();
      begin
        wait (sent_cnt == 300);
        hold_off = 1'b1;
      end
    join
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("covered %0d requests (%0d add, %0d sub, %0d cross, %0d dot, %0d scale,",
             sent_cnt, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], op_cnt[4]);
    $display("  %0d length, %0d normalize, %0d unused), %0d responses checked",
             op_cnt[5], op_cnt[6], op_cnt[7], rsp_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
